FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rpf_pkg.sv
// Types, constants and register codes of the RGB pixel filter
package rpf_pkg;

    localparam int TAPS      = 11;
    localparam int HALF      = TAPS / 2;
    localparam int MAX_WIDTH = 4096;
    localparam int NUM_CH    = 3;
    localparam int CH_W      = 8;
    localparam int PX_W      = NUM_CH * CH_W;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 13;
    localparam int SEL_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = WIDTH_W;
    localparam int SAT_W     = $clog2(HALF + 1);

    // Running window sum per channel
    localparam int SUM_W       = $clog2(TAPS * 255 + 1);
    localparam int BLUR_SHIFT  = SUM_W + 5;
    localparam int BLUR_MUL    = (2 ** BLUR_SHIFT + TAPS - 1) / TAPS;
    localparam int BLUR_MUL_W  = $clog2(BLUR_MUL + 1);
    localparam int BLUR_PROD_W = SUM_W + BLUR_MUL_W;

    // Grayscale average: divide by three via reciprocal
    localparam int GRAY_SUM_W  = $clog2(3 * 255 + 1);
    localparam int GRAY_SHIFT  = GRAY_SUM_W + 2;
    localparam int GRAY_MUL    = (2 ** GRAY_SHIFT + 2) / 3;
    localparam int GRAY_MUL_W  = $clog2(GRAY_MUL + 1);
    localparam int GRAY_PROD_W = GRAY_SUM_W + GRAY_MUL_W;

    localparam int MQ_DEPTH = 4;
    localparam int MQ_AW    = $clog2(MQ_DEPTH);
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    // Output queue fill plus the result still in the back end
    localparam int NEED_W   = OQ_AW + 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHSEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd2;

    // Mode codes
    localparam logic [SEL_W-1:0] MODE_GRAY = 2'd0;
    localparam logic [SEL_W-1:0] MODE_KEEP = 2'd1;
    localparam logic [SEL_W-1:0] MODE_BLUR = 2'd2;

    // Channel select codes
    localparam logic [SEL_W-1:0] CH_BLUE  = 2'd0;
    localparam logic [SEL_W-1:0] CH_GREEN = 2'd1;
    localparam logic [SEL_W-1:0] CH_RED   = 2'd2;

    typedef struct packed {
        logic [SEL_W-1:0]   mode;
        logic [SEL_W-1:0]   chsel;
        logic [WIDTH_W-1:0] row_width;
    } t_cfg;

    // Classified pixel passed from front to back
    typedef struct packed {
        logic [PX_W-1:0]  px;
        logic             first;
        logic             last;
        logic [SAT_W-1:0] col_sat;
    } t_mid_item;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            run_last;
        logic            row_last;
    } t_result;

endpackage

FILE: hw/rtl/rpf_front.sv
// Front end: accepts pixels, tracks the column and classifies each pixel
module rpf_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rpf_pkg::t_cfg                    i_cfg,
    input  logic                             i_push,
    input  logic [rpf_pkg::CH_W-1:0]         i_in_blue,
    input  logic [rpf_pkg::CH_W-1:0]         i_in_green,
    input  logic [rpf_pkg::CH_W-1:0]         i_in_red,
    input  logic                             i_mq_full,
    output logic                             o_mq_wr,
    output rpf_pkg::t_mid_item               o_mq_item
);

    logic [rpf_pkg::COL_W-1:0]   r_col;
    logic [rpf_pkg::COL_W-1:0]   n_col;
    logic [rpf_pkg::WIDTH_W-1:0] width_eff;
    logic [rpf_pkg::WIDTH_W-1:0] col_inc;
    logic                        row_end;
    logic                        accept;

    always_comb begin
        // Clamp the row width into its legal range
        if (i_cfg.row_width == '0) begin
            width_eff = rpf_pkg::WIDTH_W'(1);
        end else if (i_cfg.row_width > rpf_pkg::WIDTH_W'(rpf_pkg::MAX_WIDTH)) begin
            width_eff = rpf_pkg::WIDTH_W'(rpf_pkg::MAX_WIDTH);
        end else begin
            width_eff = i_cfg.row_width;
        end
        col_inc = rpf_pkg::WIDTH_W'(r_col) + rpf_pkg::WIDTH_W'(1);
        row_end = (col_inc >= width_eff);
        accept  = i_push & ~i_mq_full;
        n_col   = r_col;
        if (accept) begin
            n_col = row_end ? '0 : rpf_pkg::COL_W'(col_inc);
        end

        o_mq_wr           = accept;
        o_mq_item.px      = {i_in_red, i_in_green, i_in_blue};
        o_mq_item.first   = (r_col == '0);
        o_mq_item.last    = row_end;
        o_mq_item.col_sat = (r_col >= rpf_pkg::COL_W'(rpf_pkg::HALF)) ?
                            rpf_pkg::SAT_W'(rpf_pkg::HALF) : r_col[rpf_pkg::SAT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

endmodule

FILE: hw/rtl/rpf_mid_queue.sv
// Short queue of classified pixels between front and back
module rpf_mid_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  rpf_pkg::t_mid_item   i_item,
    output logic                 o_full,
    input  logic                 i_rd,
    output rpf_pkg::t_mid_item   o_item,
    output logic                 o_empty
);

    rpf_pkg::t_mid_item          r_mem [rpf_pkg::MQ_DEPTH];
    logic [rpf_pkg::MQ_AW-1:0]   r_wp;
    logic [rpf_pkg::MQ_AW-1:0]   r_rp;
    logic [rpf_pkg::MQ_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (rpf_pkg::MQ_AW + 1)'(rpf_pkg::MQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + rpf_pkg::MQ_AW'(1);
            end
            if (i_rd) begin
                r_rp <= r_rp + rpf_pkg::MQ_AW'(1);
            end
            r_cnt <= r_cnt + (rpf_pkg::MQ_AW + 1)'(i_wr) - (rpf_pkg::MQ_AW + 1)'(i_rd);
        end
    end

endmodule

FILE: hw/rtl/rpf_back.sv
// Back end: sliding window, row-end flush and per-mode pixel arithmetic
module rpf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rpf_pkg::t_cfg                i_cfg,
    input  rpf_pkg::t_mid_item           i_mq_item,
    input  logic                         i_mq_empty,
    output logic                         o_mq_rd,
    input  logic [rpf_pkg::OQ_AW:0]      i_oq_count,
    output logic                         o_oq_wr,
    output rpf_pkg::t_result             o_oq_data,
    output logic                         o_flushing
);

    logic [rpf_pkg::PX_W-1:0]   r_win [rpf_pkg::TAPS];
    logic [rpf_pkg::PX_W-1:0]   n_win [rpf_pkg::TAPS];
    logic [rpf_pkg::SUM_W-1:0]  r_sum [rpf_pkg::NUM_CH];
    logic [rpf_pkg::SUM_W-1:0]  n_sum [rpf_pkg::NUM_CH];
    logic                       r_flush,   n_flush;
    logic [rpf_pkg::SAT_W-1:0]  r_step,    n_step;
    logic [rpf_pkg::SAT_W-1:0]  r_col_sat, n_col_sat;
    logic                       r_e_valid, n_e_valid;
    logic                       r_e_run_last, n_e_run_last;
    logic                       r_e_row_last, n_e_row_last;

    logic [rpf_pkg::NEED_W-1:0] need;
    logic                       can_go;
    logic                       load;
    logic                       step;
    logic                       shift;
    logic [rpf_pkg::PX_W-1:0]   shift_px;
    logic [rpf_pkg::SAT_W:0]    reach;

    logic [rpf_pkg::PX_W-1:0]        centre;
    logic [rpf_pkg::GRAY_PROD_W-1:0] gray_prod;
    logic [rpf_pkg::CH_W-1:0]        gray;
    logic [rpf_pkg::BLUR_PROD_W-1:0] blur_prod [rpf_pkg::NUM_CH];
    logic [rpf_pkg::CH_W-1:0]        blur      [rpf_pkg::NUM_CH];
    rpf_pkg::t_result                res;

    // Hold off while the output queue could not take every result in flight
    always_comb begin
        need   = rpf_pkg::NEED_W'(i_oq_count) + rpf_pkg::NEED_W'(r_e_valid);
        can_go = (need < rpf_pkg::NEED_W'(rpf_pkg::OQ_DEPTH));
        load   = ~r_flush & ~i_mq_empty & can_go;
        step   = r_flush & can_go;
        shift  = step | (load & ~i_mq_item.first);
        shift_px = load ? i_mq_item.px : r_win[rpf_pkg::TAPS-1];
    end

    // Window and running sums
    always_comb begin
        for (int t = 0; t < rpf_pkg::TAPS; t++) begin
            n_win[t] = r_win[t];
        end
        for (int k = 0; k < rpf_pkg::NUM_CH; k++) begin
            n_sum[k] = r_sum[k];
        end
        if (load && i_mq_item.first) begin
            for (int t = 0; t < rpf_pkg::TAPS; t++) begin
                n_win[t] = i_mq_item.px;
            end
            for (int k = 0; k < rpf_pkg::NUM_CH; k++) begin
                n_sum[k] = rpf_pkg::SUM_W'(rpf_pkg::TAPS)
                         * rpf_pkg::SUM_W'(i_mq_item.px[k*rpf_pkg::CH_W +: rpf_pkg::CH_W]);
            end
        end else if (shift) begin
            for (int t = 0; t < rpf_pkg::TAPS - 1; t++) begin
                n_win[t] = r_win[t+1];
            end
            n_win[rpf_pkg::TAPS-1] = shift_px;
            for (int k = 0; k < rpf_pkg::NUM_CH; k++) begin
                n_sum[k] = r_sum[k]
                         + rpf_pkg::SUM_W'(shift_px[k*rpf_pkg::CH_W +: rpf_pkg::CH_W])
                         - rpf_pkg::SUM_W'(r_win[0][k*rpf_pkg::CH_W +: rpf_pkg::CH_W]);
            end
        end
    end

    // Sequencing: at most one emission per pixel (none before column HALF), up to HALF+1 at a row end
    always_comb begin
        n_flush      = r_flush;
        n_step       = r_step;
        n_col_sat    = r_col_sat;
        n_e_valid    = 1'b0;
        n_e_run_last = 1'b0;
        n_e_row_last = 1'b0;
        reach        = (rpf_pkg::SAT_W + 1)'(r_col_sat) + (rpf_pkg::SAT_W + 1)'(r_step);
        if (load) begin
            n_e_valid    = (i_mq_item.col_sat == rpf_pkg::SAT_W'(rpf_pkg::HALF));
            n_e_run_last = ~i_mq_item.last;
            if (i_mq_item.last) begin
                n_flush   = 1'b1;
                n_step    = rpf_pkg::SAT_W'(1);
                n_col_sat = i_mq_item.col_sat;
            end
        end else if (step) begin
            n_e_valid    = (reach >= (rpf_pkg::SAT_W + 1)'(rpf_pkg::HALF));
            n_e_run_last = (r_step == rpf_pkg::SAT_W'(rpf_pkg::HALF));
            n_e_row_last = n_e_run_last;
            n_step       = r_step + rpf_pkg::SAT_W'(1);
            if (n_e_run_last) begin
                n_flush = 1'b0;
            end
        end
    end

    // Result arithmetic on the registered window
    always_comb begin
        centre    = r_win[rpf_pkg::HALF];
        gray_prod = rpf_pkg::GRAY_PROD_W'(
                        rpf_pkg::GRAY_SUM_W'(centre[0 +: rpf_pkg::CH_W])
                      + rpf_pkg::GRAY_SUM_W'(centre[rpf_pkg::CH_W +: rpf_pkg::CH_W])
                      + rpf_pkg::GRAY_SUM_W'(centre[2*rpf_pkg::CH_W +: rpf_pkg::CH_W]))
                  * rpf_pkg::GRAY_PROD_W'(rpf_pkg::GRAY_MUL);
        gray      = gray_prod[rpf_pkg::GRAY_SHIFT +: rpf_pkg::CH_W];
        for (int k = 0; k < rpf_pkg::NUM_CH; k++) begin
            blur_prod[k] = rpf_pkg::BLUR_PROD_W'(r_sum[k])
                         * rpf_pkg::BLUR_PROD_W'(rpf_pkg::BLUR_MUL);
            blur[k]      = blur_prod[k][rpf_pkg::BLUR_SHIFT +: rpf_pkg::CH_W];
        end

        res = '0;
        case (i_cfg.mode)
            rpf_pkg::MODE_GRAY: begin
                res.blue  = gray;
                res.green = gray;
                res.red   = gray;
            end
            rpf_pkg::MODE_KEEP: begin
                case (i_cfg.chsel)
                    rpf_pkg::CH_BLUE:  res.blue  = centre[0 +: rpf_pkg::CH_W];
                    rpf_pkg::CH_GREEN: res.green = centre[rpf_pkg::CH_W +: rpf_pkg::CH_W];
                    rpf_pkg::CH_RED:   res.red   = centre[2*rpf_pkg::CH_W +: rpf_pkg::CH_W];
                    default: ;
                endcase
            end
            rpf_pkg::MODE_BLUR: begin
                res.blue  = blur[0];
                res.green = blur[1];
                res.red   = blur[2];
            end
            default: ;
        endcase
        res.run_last = r_e_run_last;
        res.row_last = r_e_row_last;
    end

    assign o_mq_rd    = load;
    assign o_oq_wr    = r_e_valid;
    assign o_oq_data  = res;
    assign o_flushing = r_flush;

    always_ff @(posedge i_clk) begin
        r_win        <= n_win;
        r_sum        <= n_sum;
        r_col_sat    <= n_col_sat;
        r_e_run_last <= n_e_run_last;
        r_e_row_last <= n_e_row_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush   <= 1'b0;
            r_step    <= '0;
            r_e_valid <= 1'b0;
        end else begin
            r_flush   <= n_flush;
            r_step    <= n_step;
            r_e_valid <= n_e_valid;
        end
    end

endmodule

FILE: hw/rtl/rpf_out_queue.sv
// Output queue holding finished result pixels for the receiver
module rpf_out_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr,
    input  rpf_pkg::t_result         i_data,
    input  logic                     i_rd,
    output rpf_pkg::t_result         o_data,
    output logic                     o_empty,
    output logic                     o_full,
    output logic [rpf_pkg::OQ_AW:0]  o_count
);

    rpf_pkg::t_result            r_mem [rpf_pkg::OQ_DEPTH];
    logic [rpf_pkg::OQ_AW-1:0]   r_wp;
    logic [rpf_pkg::OQ_AW-1:0]   r_rp;
    logic [rpf_pkg::OQ_AW:0]     r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (rpf_pkg::OQ_AW + 1)'(rpf_pkg::OQ_DEPTH));
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + rpf_pkg::OQ_AW'(1);
            end
            if (i_rd) begin
                r_rp <= r_rp + rpf_pkg::OQ_AW'(1);
            end
            r_cnt <= r_cnt + (rpf_pkg::OQ_AW + 1)'(i_wr) - (rpf_pkg::OQ_AW + 1)'(i_rd);
        end
    end

endmodule

FILE: hw/rtl/rgb_pixel_filter.sv
// RGB pixel filter top level: grayscale, channel keep or horizontal box blur
//
// Pixels enter on a queue-style port: one transaction when push is high and
// full is low. Results leave the same way: the oldest result sits on the
// o_out_* ports while empty is low and is taken when pop is high.
// Configuration (mode, channel select, row width) is written through
// i_cfg_wen / i_cfg_idx / i_cfg_data while no pixel is in flight.
// Each result belongs to the pixel five columns back; the last pixel of a
// row releases the rest of that row. The first result a pixel releases goes
// through the classifier queue, the back-end registers and the output queue;
// a row end releases the rest one per cycle while the output queue has room.
// Throughput is one pixel per cycle inside a row while the receiver keeps up.
// The back end takes no pixels from the classifier queue while it flushes at
// each row end; the four-entry classifier queue keeps taking pixels meanwhile
// and full rises once it fills.
// When the receiver stalls, the eight-entry output queue fills, the back end
// holds, then the classifier queue fills and full rises.
// Reset is synchronous and clears the column count, queues, back-end control state and
// configuration (mode 0, channel 0, row width 1); there is no clearing pass.
module rgb_pixel_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [rpf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rpf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [rpf_pkg::CH_W-1:0]          i_in_blue,
    input  logic [rpf_pkg::CH_W-1:0]          i_in_green,
    input  logic [rpf_pkg::CH_W-1:0]          i_in_red,
    output logic                              empty,
    input  logic                              pop,
    output logic [rpf_pkg::CH_W-1:0]          o_out_blue,
    output logic [rpf_pkg::CH_W-1:0]          o_out_green,
    output logic [rpf_pkg::CH_W-1:0]          o_out_red,
    output logic                              o_run_last,
    output logic                              o_row_last
);

    rpf_pkg::t_cfg              r_cfg;
    rpf_pkg::t_mid_item         mq_wr_item;
    rpf_pkg::t_mid_item         mq_rd_item;
    logic                       mq_wr;
    logic                       mq_rd;
    logic                       mq_full;
    logic                       mq_empty;
    logic                       oq_wr;
    logic                       oq_rd;
    logic                       oq_full;
    logic [rpf_pkg::OQ_AW:0]    oq_count;
    rpf_pkg::t_result           oq_wr_data;
    rpf_pkg::t_result           oq_rd_data;
    logic                       flushing;
    logic                       oq_last_pop;
    logic                       oq_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= rpf_pkg::MODE_GRAY;
            r_cfg.chsel     <= rpf_pkg::CH_BLUE;
            r_cfg.row_width <= rpf_pkg::WIDTH_W'(1);
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                rpf_pkg::REG_MODE:  r_cfg.mode      <= i_cfg_data[rpf_pkg::SEL_W-1:0];
                rpf_pkg::REG_CHSEL: r_cfg.chsel     <= i_cfg_data[rpf_pkg::SEL_W-1:0];
                rpf_pkg::REG_WIDTH: r_cfg.row_width <= i_cfg_data[rpf_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    rpf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .i_in_blue  (i_in_blue),
        .i_in_green (i_in_green),
        .i_in_red   (i_in_red),
        .i_mq_full  (mq_full),
        .o_mq_wr    (mq_wr),
        .o_mq_item  (mq_wr_item)
    );

    rpf_mid_queue u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (mq_wr),
        .i_item  (mq_wr_item),
        .o_full  (mq_full),
        .i_rd    (mq_rd),
        .o_item  (mq_rd_item),
        .o_empty (mq_empty)
    );

    rpf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_mq_item  (mq_rd_item),
        .i_mq_empty (mq_empty),
        .o_mq_rd    (mq_rd),
        .i_oq_count (oq_count),
        .o_oq_wr    (oq_wr),
        .o_oq_data  (oq_wr_data),
        .o_flushing (flushing)
    );

    assign oq_rd = pop & ~empty;

    rpf_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (oq_wr),
        .i_data  (oq_wr_data),
        .i_rd    (oq_rd),
        .o_data  (oq_rd_data),
        .o_empty (empty),
        .o_full  (oq_full),
        .o_count (oq_count)
    );

    assign full        = mq_full;
    assign o_out_blue  = oq_rd_data.blue;
    assign o_out_green = oq_rd_data.green;
    assign o_out_red   = oq_rd_data.red;
    assign o_run_last  = oq_rd_data.run_last;
    assign o_row_last  = oq_rd_data.row_last;

    assign oq_last_pop = oq_rd & (oq_count == (rpf_pkg::OQ_AW + 1)'(1)) & ~oq_wr;
    assign oq_row_end  = ~empty & o_row_last;

`include "assert_macros.svh"

    `ASSERT_NEVER(a_oq_overflow, i_clk, i_rst_n, oq_wr && oq_full, "output queue overflow")
    `ASSERT_NEVER(a_mq_underflow, i_clk, i_rst_n, mq_rd && mq_empty, "pixel queue underflow")
    `ASSERT_IMPL(a_flush_holds_queue, i_clk, i_rst_n, flushing, !mq_rd, "pop during flush")
    `ASSERT_IMPL(a_row_end_ends_run, i_clk, i_rst_n, oq_row_end, o_run_last, "row end not run end")
    `ASSERT_NEXT(a_last_pop_drains, i_clk, i_rst_n, oq_last_pop, empty, "queue not drained")

endmodule

FILE: bench/rpf_checker.sv
// Scoreboard for the RGB pixel filter: watches both queue ports, predicts and compares
module rpf_checker
    import rpf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [CH_W-1:0]      i_in_blue,
    input  logic [CH_W-1:0]      i_in_green,
    input  logic [CH_W-1:0]      i_in_red,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  logic [CH_W-1:0]      i_out_blue,
    input  logic [CH_W-1:0]      i_out_green,
    input  logic [CH_W-1:0]      i_out_red,
    input  logic                 i_run_last,
    input  logic                 i_row_last,
    output int                   o_errors,
    output int                   o_pending
);

    typedef logic [PX_W-1:0] t_pixels [TAPS];

    logic [SEL_W-1:0]   cur_mode;
    logic [SEL_W-1:0]   cur_chsel;
    logic [WIDTH_W-1:0] cur_width;
    logic [PX_W-1:0]    recent_px [TAPS-1];
    int                 next_col;
    t_result            pending_results [$];
    int                 fail_count = 0;

    assign o_errors = fail_count;

    // Filter the centre pixel of a window under the current mode
    function automatic t_result filter_pixel(input t_pixels win, input logic row_end);
        t_result         res;
        logic [PX_W-1:0] c;
        int              acc [NUM_CH];
        res = '0;
        c   = win[HALF];
        case (cur_mode)
            MODE_GRAY: begin
                acc[0] = (int'(c[CH_W-1:0]) + int'(c[2*CH_W-1:CH_W])
                          + int'(c[PX_W-1:2*CH_W])) / 3;
                res.blue  = CH_W'(acc[0]);
                res.green = CH_W'(acc[0]);
                res.red   = CH_W'(acc[0]);
            end
            MODE_KEEP: begin
                case (cur_chsel)
                    CH_BLUE:  res.blue  = c[CH_W-1:0];
                    CH_GREEN: res.green = c[2*CH_W-1:CH_W];
                    CH_RED:   res.red   = c[PX_W-1:2*CH_W];
                    default: ;
                endcase
            end
            MODE_BLUR: begin
                for (int k = 0; k < NUM_CH; k++) begin
                    acc[k] = 0;
                    for (int t = 0; t < TAPS; t++)
                        acc[k] += int'(win[t][CH_W*k +: CH_W]);
                end
                res.blue  = CH_W'(acc[0] / TAPS);
                res.green = CH_W'(acc[1] / TAPS);
                res.red   = CH_W'(acc[2] / TAPS);
            end
            default: ;
        endcase
        res.row_last = row_end;
        return res;
    endfunction

    // Advance the row state by one pixel and queue the results it releases
    task automatic take_pixel(input logic [PX_W-1:0] px);
        t_pixels win;
        t_result released [$];
        int      width;
        int      col;
        width = int'(cur_width);
        if (width == 0)
            width = 1;
        if (width > MAX_WIDTH)
            width = MAX_WIDTH;
        col = next_col;
        // First pixel of a row stands in for every neighbour to its left
        for (int t = 0; t < TAPS - 1; t++)
            win[t] = (col == 0) ? px : recent_px[t];
        win[TAPS-1] = px;
        if (col + 1 < width) begin
            if (col >= HALF)
                released.push_back(filter_pixel(win, 1'b0));
            next_col = col + 1;
        end else begin
            // Row end: flush, replicating the last pixel to the right
            for (int s = 0; s <= HALF; s++) begin
                if (s > 0) begin
                    for (int t = 0; t < TAPS - 1; t++)
                        win[t] = win[t+1];
                    win[TAPS-1] = px;
                end
                if (col + s >= HALF)
                    released.push_back(filter_pixel(win, s == HALF));
            end
            next_col = 0;
        end
        for (int t = 0; t < TAPS - 1; t++)
            recent_px[t] = win[t+1];
        if (released.size() > 0)
            released[released.size()-1].run_last = 1'b1;
        foreach (released[i])
            pending_results.push_back(released[i]);
    endtask

    function automatic void compare_field(input string name, input logic [CH_W-1:0] want,
                                          input logic [CH_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            $error("result with nothing expected: blue %0d green %0d red %0d",
                   i_out_blue, i_out_green, i_out_red);
            fail_count++;
        end else begin
            want = pending_results.pop_front();
            compare_field("out_blue", want.blue, i_out_blue);
            compare_field("out_green", want.green, i_out_green);
            compare_field("out_red", want.red, i_out_red);
            compare_field("run_last", CH_W'(want.run_last), CH_W'(i_run_last));
            compare_field("row_last", CH_W'(want.row_last), CH_W'(i_row_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode  = MODE_GRAY;
            cur_chsel = CH_BLUE;
            cur_width = WIDTH_W'(1);
            next_col  = 0;
            for (int t = 0; t < TAPS - 1; t++)
                recent_px[t] = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    REG_MODE:  cur_mode  = i_cfg_data[SEL_W-1:0];
                    REG_CHSEL: cur_chsel = i_cfg_data[SEL_W-1:0];
                    REG_WIDTH: cur_width = i_cfg_data[WIDTH_W-1:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                take_pixel({i_in_red, i_in_green, i_in_blue});
            if (i_pop && !i_empty)
                check_result();
        end
        o_pending <= pending_results.size();
    end

endmodule

FILE: bench/tb.sv
// Testbench top for the RGB pixel filter: clock, reset, pixel and register stimulus, verdict
module tb
    import rpf_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 24;
    localparam int TAIL        = 40;
    localparam int IDLE_PCT    = 14;
    localparam int RANDOM_PX   = 350;
    localparam int CALM_END    = 190;

    localparam logic [SEL_W-1:0] MODE_NONE = 2'd3;
    localparam logic [SEL_W-1:0] CH_NONE   = 2'd3;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_wen  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = REG_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  push     = 1'b0;
    logic                  full;
    logic [CH_W-1:0]       in_blue  = '0;
    logic [CH_W-1:0]       in_green = '0;
    logic [CH_W-1:0]       in_red   = '0;
    logic                  empty;
    logic                  pop      = 1'b0;
    logic [CH_W-1:0]       out_blue;
    logic [CH_W-1:0]       out_green;
    logic [CH_W-1:0]       out_red;
    logic                  run_last;
    logic                  row_last;

    int   error_count;
    int   pending;
    int   cycle_count = 0;
    int   pixels_sent = 0;
    logic idle_en     = 1'b1;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rgb_pixel_filter u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .push        (push),
        .full        (full),
        .i_in_blue   (in_blue),
        .i_in_green  (in_green),
        .i_in_red    (in_red),
        .empty       (empty),
        .pop         (pop),
        .o_out_blue  (out_blue),
        .o_out_green (out_green),
        .o_out_red   (out_red),
        .o_run_last  (run_last),
        .o_row_last  (row_last)
    );

    rpf_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_push      (push),
        .i_full      (full),
        .i_in_blue   (in_blue),
        .i_in_green  (in_green),
        .i_in_red    (in_red),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_out_blue  (out_blue),
        .i_out_green (out_green),
        .i_out_red   (out_red),
        .i_run_last  (run_last),
        .i_row_last  (row_last),
        .o_errors    (error_count),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: stall at random unless idling is switched off
    always @(posedge clk)
        pop <= !idle_en || ($urandom_range(99) >= IDLE_PCT);

    function automatic logic [CH_W-1:0] rand_byte();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(255));
        endcase
    endfunction

    // Hold push until the transaction is taken
    task automatic send_pixel(input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] r);
        if (idle_en) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
        push     <= 1'b1;
        in_blue  <= b;
        in_green <= g;
        in_red   <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pixels_sent++;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_byte(), rand_byte(), rand_byte());
    endtask

    // Drain every result and let the pipeline settle before touching a register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wen  <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    initial begin
        logic [SEL_W-1:0]      mode;
        logic [CFG_DATA_W-1:0] width;
        int                    pick;
        int                    eff_width;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: grayscale, one-pixel rows
        send_pixel('0, '0, '0);
        send_pixel('1, '1, '1);

        // Short row in grayscale
        write_reg(REG_WIDTH, CFG_DATA_W'(3));
        send_pixel('1, '0, '0);
        send_pixel('0, '1, '0);
        send_pixel('0, '0, '1);

        // Channel keep, every selector
        write_reg(REG_WIDTH, CFG_DATA_W'(1));
        write_reg(REG_MODE, CFG_DATA_W'(MODE_KEEP));
        write_reg(REG_CHSEL, CFG_DATA_W'(CH_BLUE));
        send_pixel(8'h5a, 8'hc3, 8'h81);
        write_reg(REG_CHSEL, CFG_DATA_W'(CH_GREEN));
        send_pixel(8'h5a, 8'hc3, 8'h81);
        write_reg(REG_CHSEL, CFG_DATA_W'(CH_RED));
        send_pixel(8'h5a, 8'hc3, 8'h81);
        write_reg(REG_CHSEL, CFG_DATA_W'(CH_NONE));
        send_pixel('1, '1, '1);

        write_reg(REG_MODE, CFG_DATA_W'(MODE_NONE));
        send_pixel('1, '1, '1);

        // Blur, then shorten the row under a pixel already past the new end
        write_reg(REG_MODE, CFG_DATA_W'(MODE_BLUR));
        write_reg(REG_WIDTH, CFG_DATA_W'(13));
        for (int i = 0; i < 8; i++)
            send_pixel(i[0] ? '1 : '0, i[1] ? '1 : '0, rand_byte());
        write_reg(REG_WIDTH, CFG_DATA_W'(5));
        send_pixel(8'h80, 8'h7f, 8'h01);

        // Width zero, then the widest setting cut short
        write_reg(REG_WIDTH, '0);
        send_random(2);
        write_reg(REG_WIDTH, '1);
        send_random(3);
        write_reg(REG_WIDTH, CFG_DATA_W'(2));
        send_random(1);

        pixels_sent = 0;
        idle_en     = 1'b0;
        while (pixels_sent < RANDOM_PX) begin
            mode = ($urandom_range(99) < 8) ? MODE_NONE : SEL_W'($urandom_range(2));
            write_reg(REG_MODE, CFG_DATA_W'(mode));
            write_reg(REG_CHSEL, CFG_DATA_W'($urandom_range(3)));
            pick = $urandom_range(99);
            if (pick < 5)
                width = '0;
            else if (pick < 10)
                width = CFG_DATA_W'(1);
            else if (pick < 80)
                width = CFG_DATA_W'($urandom_range(24, 2));
            else
                width = CFG_DATA_W'($urandom_range(90, 25));
            write_reg(REG_WIDTH, width);
            eff_width = (width == 0) ? 1 : int'(width);
            repeat ($urandom_range(3, 1)) begin
                send_random(eff_width);
                if (pixels_sent >= CALM_END)
                    idle_en = 1'b1;
            end
            // Leave a row unfinished now and then for the next setting to pick up
            if ($urandom_range(3) == 0)
                send_random($urandom_range(8, 1));
        end

        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
